// ----- design/edtq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edtq_pkg
// shared types, codes and defaults for the earliest deadline timer queue
// ----------------------------------------------------------------------------
package edtq_pkg;

    localparam int JOB_DEPTH_DEF      = 16;
    localparam int PERIODIC_DEPTH_DEF = 16;

    localparam int CMD_W     = 2;
    localparam int DUE_W     = 32;
    localparam int TASK_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int PENDING_W = 5;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_ADD_ONESHOT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_PERIODIC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK         = 2'd2;

    // status codes on the result channel
    localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_JOB_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PERIODIC_FULL = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD_ONESHOT,
        OP_ADD_PERIODIC,
        OP_TICK,
        OP_NOP
    } op_kind_t;

    // classified command handed from the front to the back
    typedef struct packed {
        op_kind_t            kind;
        logic [DUE_W-1:0]    due;
        logic [DUE_W-1:0]    now;
        logic [DUE_W-1:0]    period;
        logic [TASK_W-1:0]   task_id;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_REARM
    } back_state_t;

endpackage

// ----- design/edtq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edtq_front
// accepts commands, classifies them and buffers them in a two-entry queue
// ----------------------------------------------------------------------------
module edtq_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [edtq_pkg::CMD_W-1:0]   s_cmd,
    input  logic [edtq_pkg::DUE_W-1:0]   s_now_ms,
    input  logic [edtq_pkg::DUE_W-1:0]   s_value_ms,
    input  logic [edtq_pkg::TASK_W-1:0]  s_task_id,
    output edtq_pkg::op_t                op_data,
    output logic                         op_valid,
    input  logic                         op_ready
);
    import edtq_pkg::*;

    op_t        q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    op_t        op_c;
    logic       push, pop;

    // classify
    always_comb begin
        op_c         = '0;
        op_c.now     = s_now_ms;
        op_c.period  = s_value_ms;
        op_c.task_id = s_task_id;
        op_c.due     = s_value_ms;
        unique case (s_cmd)
            CMD_ADD_ONESHOT: begin
                op_c.kind = OP_ADD_ONESHOT;
            end
            CMD_ADD_PERIODIC: begin
                op_c.kind = OP_ADD_PERIODIC;
                op_c.due  = s_now_ms + s_value_ms;
            end
            CMD_TICK: begin
                op_c.kind = OP_TICK;
            end
            default: begin
                op_c.kind = OP_NOP;
            end
        endcase
    end

    assign s_ready  = (fill_reg != 2'd2);
    assign op_valid = (fill_reg != 2'd0);
    assign op_data  = q_reg[rd_ptr_reg];
    assign push     = s_valid && s_ready;
    assign pop      = op_valid && op_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= op_c;
        end
    end

endmodule

// ----- design/edtq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edtq_back
// job and periodic tables, earliest-deadline scan, removal and re-arm
// ----------------------------------------------------------------------------
module edtq_back #(
    parameter int JOB_DEPTH      = edtq_pkg::JOB_DEPTH_DEF,
    parameter int PERIODIC_DEPTH = edtq_pkg::PERIODIC_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  edtq_pkg::op_t                  op_data,
    input  logic                           op_valid,
    output logic                           op_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_fired,
    output logic [edtq_pkg::TASK_W-1:0]    m_fired_task,
    output logic [edtq_pkg::STATUS_W-1:0]  m_status,
    output logic [edtq_pkg::PENDING_W-1:0] m_pending
);
    import edtq_pkg::*;

    localparam int IDX_W  = $clog2(JOB_DEPTH);
    localparam int CNT_W  = $clog2(JOB_DEPTH + 1);
    localparam int LINK_W = (PERIODIC_DEPTH > 1) ? $clog2(PERIODIC_DEPTH) : 1;
    localparam int PCNT_W = $clog2(PERIODIC_DEPTH + 1);
    localparam int WORD_W = 1 + LINK_W + TASK_W + DUE_W;
    localparam int PER_W  = TASK_W + DUE_W;

    localparam logic [CNT_W-1:0]  JOB_FULL = CNT_W'(JOB_DEPTH);
    localparam logic [PCNT_W-1:0] PER_FULL = PCNT_W'(PERIODIC_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);

    // storage
    logic [WORD_W-1:0] job_mem [JOB_DEPTH];
    logic [PER_W-1:0]  per_mem [PERIODIC_DEPTH];

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PCNT_W-1:0] pcount_reg, pcount_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              rvalid_reg;
    logic [CNT_W-1:0]  ridx_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic [PER_W-1:0]  per_data_reg;
    logic [DUE_W-1:0]  now_reg, now_next;
    logic [DUE_W-1:0]  best_due_reg, best_due_next;
    logic [TASK_W-1:0] best_task_reg, best_task_next;
    logic [LINK_W-1:0] best_link_reg, best_link_next;
    logic              best_linked_reg, best_linked_next;
    logic [CNT_W-1:0]  best_idx_reg, best_idx_next;

    logic                m_valid_reg;
    logic                m_fired_reg;
    logic [TASK_W-1:0]   m_fired_task_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [PENDING_W-1:0] m_pending_reg;

    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              per_wr;
    logic              per_rd;
    logic              finish;
    logic              res_fired;
    logic [STATUS_W-1:0] res_status;
    logic [CNT_W-1:0]  count_last;
    logic [CNT_W-1:0]  ridx_dec;
    logic [CNT_W-1:0]  best_after;
    logic [CNT_W+PENDING_W-1:0] pending_ext;

    logic [DUE_W-1:0]  r_due;
    logic [TASK_W-1:0] r_task;
    logic [LINK_W-1:0] r_link;
    logic              r_linked;
    logic [DUE_W-1:0]  p_period;
    logic [TASK_W-1:0] p_task;
    logic [DUE_W-1:0]  rearm_due;

    assign r_due      = rd_data_reg[DUE_W-1:0];
    assign r_task     = rd_data_reg[DUE_W +: TASK_W];
    assign r_link     = rd_data_reg[DUE_W+TASK_W +: LINK_W];
    assign r_linked   = rd_data_reg[WORD_W-1];
    assign p_period   = per_data_reg[DUE_W-1:0];
    assign p_task     = per_data_reg[DUE_W +: TASK_W];
    assign rearm_due  = now_reg + p_period;
    assign count_last = count_reg - CNT_ONE;
    assign ridx_dec   = ridx_reg - CNT_ONE;
    assign best_after = best_idx_reg + CNT_ONE;

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        pcount_next      = pcount_reg;
        scan_next        = scan_reg;
        now_next         = now_reg;
        best_due_next    = best_due_reg;
        best_task_next   = best_task_reg;
        best_link_next   = best_link_reg;
        best_linked_next = best_linked_reg;
        best_idx_next    = best_idx_reg;
        op_ready         = 1'b0;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = count_reg[IDX_W-1:0];
        wr_data          = '0;
        per_wr           = 1'b0;
        per_rd           = 1'b0;
        finish           = 1'b0;
        res_fired        = 1'b0;
        res_status       = STATUS_OK;

        unique case (state_reg)
            ST_IDLE: begin
                if (op_valid && !m_valid_reg) begin
                    op_ready = 1'b1;
                    now_next = op_data.now;
                    unique case (op_data.kind)
                        OP_ADD_ONESHOT: begin
                            finish = 1'b1;
                            if (count_reg == JOB_FULL) begin
                                res_status = STATUS_JOB_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_data    = {1'b0, LINK_W'(0), op_data.task_id, op_data.due};
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        OP_ADD_PERIODIC: begin
                            finish = 1'b1;
                            if (count_reg == JOB_FULL) begin
                                res_status = STATUS_JOB_FULL;
                            end else if (pcount_reg == PER_FULL) begin
                                res_status = STATUS_PERIODIC_FULL;
                            end else begin
                                per_wr      = 1'b1;
                                wr_en       = 1'b1;
                                wr_data     = {1'b1, pcount_reg[LINK_W-1:0],
                                               op_data.task_id, op_data.due};
                                count_next  = count_reg + CNT_ONE;
                                pcount_next = pcount_reg + PCNT_W'(1);
                            end
                        end
                        OP_TICK: begin
                            if (count_reg == '0) begin
                                finish = 1'b1;
                            end else begin
                                scan_next  = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_reg < count_reg) begin
                    rd_en     = 1'b1;
                    scan_next = scan_reg + CNT_ONE;
                end
                if (rvalid_reg) begin
                    // strict less-than keeps the oldest entry on a tie
                    if (ridx_reg == '0 || r_due < best_due_reg) begin
                        best_due_next    = r_due;
                        best_task_next   = r_task;
                        best_link_next   = r_link;
                        best_linked_next = r_linked;
                        best_idx_next    = ridx_reg;
                    end
                    if (ridx_reg == count_last) begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (now_reg >= best_due_reg) begin
                    per_rd = best_linked_reg;
                    if (best_after < count_reg) begin
                        scan_next  = best_after;
                        state_next = ST_SHIFT;
                    end else begin
                        count_next = count_last;
                        if (best_linked_reg) begin
                            state_next = ST_REARM;
                        end else begin
                            finish     = 1'b1;
                            res_fired  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (scan_reg < count_reg) begin
                    rd_en     = 1'b1;
                    scan_next = scan_reg + CNT_ONE;
                end
                if (rvalid_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = ridx_dec[IDX_W-1:0];
                    wr_data = rd_data_reg;
                    if (ridx_reg == count_last) begin
                        count_next = count_last;
                        if (best_linked_reg) begin
                            state_next = ST_REARM;
                        end else begin
                            finish     = 1'b1;
                            res_fired  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_REARM: begin
                wr_en      = 1'b1;
                wr_data    = {1'b1, best_link_reg, p_task, rearm_due};
                count_next = count_reg + CNT_ONE;
                finish     = 1'b1;
                res_fired  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pending_ext = {{PENDING_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pcount_reg  <= '0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pcount_reg <= pcount_next;
            rvalid_reg <= rd_en;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg        <= scan_next;
        ridx_reg        <= scan_reg;
        now_reg         <= now_next;
        best_due_reg    <= best_due_next;
        best_task_reg   <= best_task_next;
        best_link_reg   <= best_link_next;
        best_linked_reg <= best_linked_next;
        best_idx_reg    <= best_idx_next;
        if (finish) begin
            m_fired_reg      <= res_fired;
            m_fired_task_reg <= res_fired ? best_task_reg : '0;
            m_status_reg     <= res_status;
            m_pending_reg    <= pending_ext[PENDING_W-1:0];
        end
    end

    // job table: one read and one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            job_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= job_mem[scan_reg[IDX_W-1:0]];
        end
    end

    // periodic table
    always_ff @(posedge aclk) begin
        if (per_wr) begin
            per_mem[pcount_reg[LINK_W-1:0]] <= {op_data.task_id, op_data.period};
        end
        if (per_rd) begin
            per_data_reg <= per_mem[best_link_reg];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_fired      = m_fired_reg;
    assign m_fired_task = m_fired_task_reg;
    assign m_status     = m_status_reg;
    assign m_pending    = m_pending_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= JOB_FULL)
        else $error("job count above table depth");

    a_pcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pcount_reg <= PER_FULL)
        else $error("periodic count above table depth");

    a_pcount_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> pcount_reg >= $past(pcount_reg))
        else $error("periodic count went down");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rvalid_reg |-> ridx_reg < count_reg)
        else $error("job read beyond fill count");

    a_finish_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> !m_valid_reg)
        else $error("result written over a waiting result");

    a_rearm_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REARM) |-> count_reg < JOB_FULL)
        else $error("re-arm with no free job slot");

endmodule

// ----- design/earliest_deadline_timer_queue_core.sv -----
// add commands and idle ticks pass through the front queue and give their result from the idle state;
// a tick that finds jobs scans them all, then decides, then shifts the entries after a released job
// to close its gap, and re-arms a released periodic job at the end of the job table
// the job table has one read port: one entry is read per cycle in scan and shift
// reset: aresetn synchronous active low, clears counts and handshakes; tables need no clear
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_deadline_timer_queue_core
// timer queue that releases the earliest due job per tick and re-arms periodics
// ----------------------------------------------------------------------------
module earliest_deadline_timer_queue_core #(
    parameter int JOB_DEPTH      = edtq_pkg::JOB_DEPTH_DEF,
    parameter int PERIODIC_DEPTH = edtq_pkg::PERIODIC_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // command channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [edtq_pkg::CMD_W-1:0]     s_cmd,
    input  logic [edtq_pkg::DUE_W-1:0]     s_now_ms,
    input  logic [edtq_pkg::DUE_W-1:0]     s_value_ms,
    input  logic [edtq_pkg::TASK_W-1:0]    s_task_id,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_fired,
    output logic [edtq_pkg::TASK_W-1:0]    m_fired_task,
    output logic [edtq_pkg::STATUS_W-1:0]  m_status,
    output logic [edtq_pkg::PENDING_W-1:0] m_pending
);
    import edtq_pkg::*;

    // classified command between front and back
    op_t  op_data;
    logic op_valid;
    logic op_ready;

    // front: takes a transaction whenever its queue has room, even while the
    // back is busy scanning or a result waits to be taken
    edtq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_now_ms   (s_now_ms),
        .s_value_ms (s_value_ms),
        .s_task_id  (s_task_id),
        .op_data    (op_data),
        .op_valid   (op_valid),
        .op_ready   (op_ready)
    );

    // back: holds the tables, runs one command at a time and owns the
    // result register
    edtq_back #(
        .JOB_DEPTH      (JOB_DEPTH),
        .PERIODIC_DEPTH (PERIODIC_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op_data      (op_data),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fired      (m_fired),
        .m_fired_task (m_fired_task),
        .m_status     (m_status),
        .m_pending    (m_pending)
    );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks earliest_deadline_timer_queue_core against a cycle-free model of its
// job and periodic tables: a short table of directed commands (empty ticks,
// field extremes, wrap of now plus period, ties on the due time, zero periods)
// followed by random commands around a moving millisecond clock, run through
// phases of sender idling and receiver stalls
// ----------------------------------------------------------------------------
module testbench;
    import edtq_pkg::*;

    localparam int JOB_DEPTH      = JOB_DEPTH_DEF;
    localparam int PERIODIC_DEPTH = PERIODIC_DEPTH_DEF;

    // command code 3 is not used by the block and must do nothing
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 212;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 2 * JOB_DEPTH + 16;

    typedef struct packed {
        logic                 fired;
        logic [TASK_W-1:0]    fired_task;
        logic [STATUS_W-1:0]  status;
        logic [PENDING_W-1:0] pending;
    } outcome_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DUE_W-1:0]  now_ms;
        logic [DUE_W-1:0]  value_ms;
        logic [TASK_W-1:0] task_id;
        bit                typed;
        outcome_t          want;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd;
    logic [DUE_W-1:0]     s_now_ms;
    logic [DUE_W-1:0]     s_value_ms;
    logic [TASK_W-1:0]    s_task_id;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_fired;
    logic [TASK_W-1:0]    m_fired_task;
    logic [STATUS_W-1:0]  m_status;
    logic [PENDING_W-1:0] m_pending;

    earliest_deadline_timer_queue_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_now_ms     (s_now_ms),
        .s_value_ms   (s_value_ms),
        .s_task_id    (s_task_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fired      (m_fired),
        .m_fired_task (m_fired_task),
        .m_status     (m_status),
        .m_pending    (m_pending)
    );

    // model of the job table, kept in insert order like the block
    logic [DUE_W-1:0]  sched_due    [JOB_DEPTH];
    logic [TASK_W-1:0] sched_task   [JOB_DEPTH];
    bit                sched_linked [JOB_DEPTH];
    int                sched_link   [JOB_DEPTH];
    int                sched_count;

    // model of the periodic table, which only grows
    logic [DUE_W-1:0]  period_len  [PERIODIC_DEPTH];
    logic [TASK_W-1:0] period_task [PERIODIC_DEPTH];
    int                period_count;

    // results still owed by the block, oldest first
    outcome_t          owed_outcomes [$];
    stim_row_t         directed_rows [$];

    int                fail_count;
    int                result_count;
    int                idle_cycles;
    int                send_idle_pct;
    int                stall_pct;
    logic [DUE_W-1:0]  wall_ms;

    // clock and receiver
    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= stall_pct);
    end

    // table model helpers
    function automatic void sched_append(input logic [DUE_W-1:0] due,
                                         input logic [TASK_W-1:0] tid,
                                         input bit linked, input int link);
        if (sched_count < JOB_DEPTH) begin
            sched_due[sched_count]    = due;
            sched_task[sched_count]   = tid;
            sched_linked[sched_count] = linked;
            sched_link[sched_count]   = link;
            sched_count++;
        end
    endfunction

    // one command applied to the model; returns the outcome it must produce
    function automatic outcome_t timer_queue_step(input logic [CMD_W-1:0] cmd,
                                                  input logic [DUE_W-1:0] now_ms,
                                                  input logic [DUE_W-1:0] value_ms,
                                                  input logic [TASK_W-1:0] tid);
        outcome_t res;
        int       best;
        bit       linked;
        int       link;
        res = '0;
        case (cmd)
            CMD_ADD_ONESHOT: begin
                if (sched_count >= JOB_DEPTH)
                    res.status = STATUS_JOB_FULL;
                else
                    sched_append(value_ms, tid, 1'b0, 0);
            end
            CMD_ADD_PERIODIC: begin
                if (sched_count >= JOB_DEPTH) begin
                    res.status = STATUS_JOB_FULL;
                end else if (period_count >= PERIODIC_DEPTH) begin
                    res.status = STATUS_PERIODIC_FULL;
                end else begin
                    period_len[period_count]  = value_ms;
                    period_task[period_count] = tid;
                    sched_append(now_ms + value_ms, tid, 1'b1, period_count);
                    period_count++;
                end
            end
            CMD_TICK: begin
                if (sched_count > 0) begin
                    // earliest due wins, strict compare keeps the oldest on a tie
                    best = 0;
                    for (int i = 1; i < sched_count; i++)
                        if (sched_due[i] < sched_due[best])
                            best = i;
                    if (now_ms >= sched_due[best]) begin
                        res.fired      = 1'b1;
                        res.fired_task = sched_task[best];
                        linked         = sched_linked[best];
                        link           = sched_link[best];
                        // close the gap, keeping insert order
                        for (int i = best; i + 1 < sched_count; i++) begin
                            sched_due[i]    = sched_due[i + 1];
                            sched_task[i]   = sched_task[i + 1];
                            sched_linked[i] = sched_linked[i + 1];
                            sched_link[i]   = sched_link[i + 1];
                        end
                        sched_count--;
                        // periodic job goes back in at the end, now plus period
                        if (linked)
                            sched_append(now_ms + period_len[link], period_task[link],
                                         1'b1, link);
                    end
                end
            end
            default: begin
            end
        endcase
        res.pending = PENDING_W'(sched_count);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("result %0d: %s is %0h, expected %0h", result_count, field, got, want);
        fail_count++;
    endtask

    // result checker: every result transaction against the oldest owed outcome
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_outcomes.size() == 0) begin
                $display("result %0d: arrived with nothing expected", result_count);
                fail_count++;
            end else begin
                want = owed_outcomes.pop_front();
                if (m_fired !== want.fired)
                    report_mismatch("fired", m_fired, want.fired);
                if (m_fired_task !== want.fired_task)
                    report_mismatch("fired_task", m_fired_task, want.fired_task);
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_pending !== want.pending)
                    report_mismatch("pending", m_pending, want.pending);
            end
            result_count++;
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // drive one command transaction; valid stays high across back-to-back items
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DUE_W-1:0] now_ms,
                                input logic [DUE_W-1:0] value_ms,
                                input logic [TASK_W-1:0] tid,
                                input bit typed, input outcome_t want);
        outcome_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_cmd      = cmd;
        s_now_ms   = now_ms;
        s_value_ms = value_ms;
        s_task_id  = tid;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // accepted at this edge: the model moves on, typed rows owe their typed result
        predicted = timer_queue_step(cmd, now_ms, value_ms, tid);
        owed_outcomes = {owed_outcomes, (typed ? want : predicted)};
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [DUE_W-1:0] now_ms,
                           input logic [DUE_W-1:0] value_ms, input logic [TASK_W-1:0] tid,
                           input bit typed, input logic fired, input logic [TASK_W-1:0] ftask,
                           input logic [STATUS_W-1:0] status,
                           input logic [PENDING_W-1:0] pending);
        stim_row_t row;
        row.cmd      = cmd;
        row.now_ms   = now_ms;
        row.value_ms = value_ms;
        row.task_id  = tid;
        row.typed    = typed;
        row.want     = '{fired, ftask, status, pending};
        directed_rows = {directed_rows, row};
    endtask

    // random command around a slowly moving clock; periodic adds stay rare since
    // periodic jobs never leave the table
    task automatic send_random_command();
        logic [CMD_W-1:0]  cmd;
        logic [DUE_W-1:0]  now_ms;
        logic [DUE_W-1:0]  value_ms;
        int                pick;
        outcome_t          unused_want;
        unused_want = '0;
        wall_ms = wall_ms + $urandom_range(0, 6);
        if ($urandom_range(49) == 0)
            wall_ms = $urandom;
        pick = $urandom_range(99);
        if (pick < 46)
            cmd = CMD_ADD_ONESHOT;
        else if (pick < 48)
            cmd = CMD_ADD_PERIODIC;
        else if (pick < 96)
            cmd = CMD_TICK;
        else
            cmd = CMD_UNUSED;

        // now: mostly the running clock, sometimes anywhere or at an extreme
        pick = $urandom_range(19);
        if (pick == 0)
            now_ms = $urandom;
        else if (pick == 1)
            now_ms = '1;
        else
            now_ms = wall_ms;

        pick = $urandom_range(19);
        if (cmd == CMD_ADD_PERIODIC) begin
            if (pick < 14)
                value_ms = $urandom_range(1, 40);
            else if (pick < 16)
                value_ms = '0;
            else
                value_ms = $urandom;
        end else begin
            // due time: near future, already due, anywhere, or an extreme
            if (pick < 13)
                value_ms = wall_ms + $urandom_range(0, 30);
            else if (pick < 15)
                value_ms = wall_ms - $urandom_range(0, 10);
            else if (pick < 18)
                value_ms = $urandom;
            else if (pick == 18)
                value_ms = '0;
            else
                value_ms = '1;
        end
        send_command(cmd, now_ms, value_ms, TASK_W'($urandom), 1'b0, unused_want);
    endtask

    int idle_plan  [4] = '{0, 85, 0, 18};
    int stall_plan [4] = '{0, 0, 85, 18};

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_cmd         = '0;
        s_now_ms      = '0;
        s_value_ms    = '0;
        s_task_id     = '0;
        m_ready       = 1'b0;
        fail_count    = 0;
        result_count  = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        wall_ms       = '0;
        sched_count   = 0;
        period_count  = 0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // tick on an empty table, then the unused code with every field bit set
        add_row(CMD_TICK,         32'h0,        32'h0,        8'h00, 1, 0, 8'h00, STATUS_OK, 0);
        add_row(CMD_UNUSED,       32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 1, 0, 8'h00, STATUS_OK, 0);
        // one-shots at the due time extremes
        add_row(CMD_ADD_ONESHOT,  32'h0,        32'hFFFFFFFF, 8'hFF, 1, 0, 8'h00, STATUS_OK, 1);
        add_row(CMD_ADD_ONESHOT,  32'hFFFFFFFF, 32'h0,        8'h00, 1, 0, 8'h00, STATUS_OK, 2);
        add_row(CMD_ADD_ONESHOT,  32'h0,        32'h64,       8'h01, 1, 0, 8'h00, STATUS_OK, 3);
        // due at zero releases at now zero
        add_row(CMD_TICK,         32'h0,        32'h0,        8'h00, 1, 1, 8'h00, STATUS_OK, 2);
        // one short of the earliest due time: nothing released
        add_row(CMD_TICK,         32'h63,       32'h0,        8'h00, 0, 0, 8'h00, STATUS_OK, 0);
        // periodic add whose due time wraps past the top
        add_row(CMD_ADD_PERIODIC, 32'hFFFFFFF0, 32'h20,       8'h22, 0, 0, 8'h00, STATUS_OK, 0);
        add_row(CMD_TICK,         32'h10,       32'h0,        8'h00, 0, 0, 8'h00, STATUS_OK, 0);
        // one-shot tied with the re-armed periodic: older insert goes first
        add_row(CMD_ADD_ONESHOT,  32'h0,        32'h30,       8'h33, 0, 0, 8'h00, STATUS_OK, 0);
        add_row(CMD_TICK,         32'h2F,       32'h0,        8'h00, 0, 0, 8'h00, STATUS_OK, 0);
        add_row(CMD_TICK,         32'h30,       32'h0,        8'h00, 0, 0, 8'h00, STATUS_OK, 0);
        add_row(CMD_TICK,         32'h30,       32'h0,        8'h00, 0, 0, 8'h00, STATUS_OK, 0);
        // re-arm at the top of the range wraps around
        add_row(CMD_TICK,         32'hFFFFFFFF, 32'h0,        8'h00, 0, 0, 8'h00, STATUS_OK, 0);
        add_row(CMD_TICK,         32'hFFFFFFFF, 32'h0,        8'h00, 0, 0, 8'h00, STATUS_OK, 0);
        // largest and zero periods
        add_row(CMD_ADD_PERIODIC, 32'h0,        32'hFFFFFFFF, 8'hAA, 0, 0, 8'h00, STATUS_OK, 0);
        add_row(CMD_ADD_PERIODIC, 32'h0,        32'h0,        8'h55, 0, 0, 8'h00, STATUS_OK, 0);
        add_row(CMD_TICK,         32'h0,        32'h0,        8'h00, 0, 0, 8'h00, STATUS_OK, 0);
        add_row(CMD_TICK,         32'h64,       32'h0,        8'h00, 0, 0, 8'h00, STATUS_OK, 0);

        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd, directed_rows[i].now_ms,
                         directed_rows[i].value_ms, directed_rows[i].task_id,
                         directed_rows[i].typed, directed_rows[i].want);

        // random commands: free running, idle sender, stalling receiver, both
        wall_ms = 32'h100;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            repeat (RANDOM_PER_PHASE) send_random_command();
        end
        @(negedge aclk);
        s_valid = 1'b0;

        // drain, then give the block time to show any stray result
        while (owed_outcomes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
